@@ src/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants of the sorted set table: request and result
// items, status codes and the command broadcast to the cell chain.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int CAPACITY_DEF = 16;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_DUMP   = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_FULL      = 3'd5,
    ST_LISTED    = 3'd6
  } status_t;

  typedef struct packed {
    req_type_t          req_type;
    logic signed [31:0] key_value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] out_value;
    logic [4:0]         entry_count;
    logic               last_result;
  } rsp_t;

  // what every cell does in the current cycle
  typedef enum logic [2:0] {
    CMD_HOLD   = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_SHIFT  = 3'd3,
    CMD_ROTATE = 3'd4
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t          cmd;
    logic signed [31:0] key;
    logic signed [31:0] head;
  } cell_ctrl_t;

endpackage

@@ src/sorted_set_table.sv @@
// ----------------------------------------------------------------------------
// sorted_set_table
// Bounded set of distinct signed values kept in ascending order in a chain
// of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Insert and delete requests are handled at once: every cell compares its
// entry with the key and the chain shifts in the same cycle, so one result
// item leaves per request. Clear and dump of n stored values first enter
// the drain state, then give one result item per value whenever the single
// result register is free: clear shifts the chain toward the head, dump
// rotates it so the table is unchanged afterward. Requests are held off
// while a clear or dump is running or while a result waits to be taken.
// Empty table requests other than insert give a single empty item.
module sorted_set_table import sst_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

  state_t             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      remaining, remaining_next;
  logic               clear_mode, clear_mode_next;
  rsp_t               rsp_next;
  logic               emit;
  logic               out_free;
  logic               accept;
  cell_ctrl_t         ctrl;
  cell_cmd_t          cmd;
  logic signed [31:0] vals [CAPACITY];
  logic [CAPACITY-1:0] gt_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic               found;
  logic               full;

  // handshake
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE) || !out_free;
  assign accept    = req_valid && !req_stall;

  assign found = |eq_vec;
  assign full  = count == CW'(CAPACITY);

  assign ctrl.cmd  = cmd;
  assign ctrl.key  = req.key_value;
  assign ctrl.head = vals[0];

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_v;
    logic signed [31:0] right_v;
    logic               left_g;
    if (i == 0) begin : g_first
      assign left_v = req.key_value;
      assign left_g = 1'b0;
    end else begin : g_inner
      assign left_v = vals[i-1];
      assign left_g = gt_vec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = vals[i];
    end else begin : g_mid
      assign right_v = vals[i+1];
    end
    sst_cell #(
      .INDEX (i),
      .CNT_W (CW)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .count        (count),
      .left_value   (left_v),
      .left_greater (left_g),
      .right_value  (right_v),
      .value        (vals[i]),
      .greater      (gt_vec[i]),
      .equal        (eq_vec[i])
    );
  end

  // request decode and drain sequencing
  always_comb begin
    state_next      = state;
    count_next      = count;
    remaining_next  = remaining;
    clear_mode_next = clear_mode;
    cmd             = CMD_HOLD;
    emit            = 1'b0;
    rsp_next        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          emit                 = 1'b1;
          rsp_next.out_value   = req.key_value;
          rsp_next.entry_count = 5'(count);
          rsp_next.last_result = 1'b1;
          unique case (req.req_type)
            REQ_INSERT: begin
              if (found) begin
                rsp_next.status = ST_DUPLICATE;
              end else if (full) begin
                rsp_next.status = ST_FULL;
              end else begin
                cmd                  = CMD_INSERT;
                count_next           = count + CW'(1);
                rsp_next.status      = ST_INSERTED;
                rsp_next.entry_count = 5'(count + CW'(1));
              end
            end
            REQ_DELETE: begin
              if (count == '0) begin
                rsp_next.status    = ST_EMPTY;
                rsp_next.out_value = '0;
              end else if (found) begin
                cmd                  = CMD_DELETE;
                count_next           = count - CW'(1);
                rsp_next.status      = ST_REMOVED;
                rsp_next.entry_count = 5'(count - CW'(1));
              end else begin
                rsp_next.status = ST_NOT_FOUND;
              end
            end
            REQ_CLEAR, REQ_DUMP: begin
              if (count == '0) begin
                rsp_next.status    = ST_EMPTY;
                rsp_next.out_value = '0;
              end else begin
                emit            = 1'b0;
                state_next      = S_DRAIN;
                remaining_next  = count;
                clear_mode_next = req.req_type == REQ_CLEAR;
              end
            end
          endcase
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          emit                 = 1'b1;
          rsp_next.out_value   = vals[0];
          rsp_next.last_result = remaining == CW'(1);
          remaining_next       = remaining - CW'(1);
          if (clear_mode) begin
            cmd                  = CMD_SHIFT;
            count_next           = count - CW'(1);
            rsp_next.status      = ST_REMOVED;
            rsp_next.entry_count = 5'(count - CW'(1));
          end else begin
            cmd                  = CMD_ROTATE;
            rsp_next.status      = ST_LISTED;
            rsp_next.entry_count = 5'(count);
          end
          if (remaining == CW'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      remaining  <= '0;
      clear_mode <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      remaining  <= remaining_next;
      clear_mode <= clear_mode_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      rsp <= rsp_next;
    end
  end

  // fill level stays within the table
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("fill level beyond capacity");

  // no request taken while a clear or dump runs
  a_drain_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> req_stall)
    else $error("request accepted during drain");

  // a fresh insert grows the table by one
  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == REQ_INSERT && !found && !full)
    |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow table");

  // final item of a clear leaves the table empty
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN && clear_mode && emit && remaining == CW'(1))
    |=> (count == '0 && state == S_IDLE))
    else $error("clear left entries behind");

  // a result is never overwritten while it waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |-> !emit)
    else $error("pending result overwritten");

endmodule

@@ src/sst_cell.sv @@
// ----------------------------------------------------------------------------
// sst_cell
// One entry of the sorted chain. Compares its value with the broadcast key
// and takes its own value, a neighbor's, the key or the head value each cycle.
// ----------------------------------------------------------------------------
module sst_cell import sst_pkg::*; #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic [CNT_W-1:0]   count,
  input  logic signed [31:0] left_value,
  input  logic               left_greater,
  input  logic signed [31:0] right_value,
  output logic signed [31:0] value,
  output logic               greater,
  output logic               equal
);

  logic               occupied;
  logic               last_occupied;
  logic signed [31:0] value_next;

  // position against fill level
  assign occupied      = CNT_W'(INDEX) < count;
  assign last_occupied = CNT_W'(INDEX + 1) == count;

  // compare with key, free entries count as greater
  assign greater = !occupied || (value > ctrl.key);
  assign equal   = occupied && (value == ctrl.key);

  // select the next value
  always_comb begin
    case (ctrl.cmd)
      CMD_INSERT: value_next = greater ? (left_greater ? left_value : ctrl.key) : value;
      CMD_DELETE: value_next = (occupied && (value >= ctrl.key)) ? right_value : value;
      CMD_SHIFT:  value_next = right_value;
      CMD_ROTATE: value_next = last_occupied ? ctrl.head : right_value;
      default:    value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted set table. Requests come from a backlog
// queue filled at start: a short directed run, then random request sequences.
// A scoreboard holds its own copy of the sorted set, works out the result
// items of every accepted request, and compares them field by field with
// what the block emits. Both sides insert random gaps.
// ----------------------------------------------------------------------------
module tb_top import sst_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ITEMS  = 310;
  localparam int WDOG_LIMIT = 4000;
  localparam int LONG_HOLD  = 200;

  typedef struct packed {
    logic drain;
    req_t r;
  } backlog_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  sorted_set_table u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  backlog_t req_backlog[$];
  rsp_t due_results[$];
  logic signed [31:0] set_vals[CAPACITY_DEF];
  int set_count = 0;
  int n_sent = 0;
  int n_err = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit long_hold_done = 0;
  logic signed [31:0] key_pool[24];

  // short phases with no idling on either side
  function automatic int pick_gap(int sent);
    int r;
    r = $urandom_range(0, 99);
    if ((sent / 40) % 3 == 2) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic rsp_t mk_result(status_t s, logic signed [31:0] v, int c, logic l);
    rsp_t x;
    x.status      = s;
    x.out_value   = v;
    x.entry_count = 5'(c);
    x.last_result = l;
    return x;
  endfunction

  // apply one request to the set copy and queue the result items it causes
  task automatic predict_set_op(input req_t r);
    int pos;
    int n;
    pos = 0;
    if (r.req_type == REQ_INSERT) begin
      while (pos < set_count && set_vals[pos] < r.key_value) pos++;
      if (pos < set_count && set_vals[pos] == r.key_value) begin
        due_results.push_back(mk_result(ST_DUPLICATE, r.key_value, set_count, 1'b1));
      end else if (set_count >= CAPACITY_DEF) begin
        due_results.push_back(mk_result(ST_FULL, r.key_value, set_count, 1'b1));
      end else begin
        for (int i = set_count; i > pos; i--) set_vals[i] = set_vals[i-1];
        set_vals[pos] = r.key_value;
        set_count++;
        due_results.push_back(mk_result(ST_INSERTED, r.key_value, set_count, 1'b1));
      end
    end else if (set_count == 0) begin
      // delete, clear or dump of an empty set
      due_results.push_back(mk_result(ST_EMPTY, '0, 0, 1'b1));
    end else if (r.req_type == REQ_DELETE) begin
      while (pos < set_count && set_vals[pos] < r.key_value) pos++;
      if (pos >= set_count || set_vals[pos] != r.key_value) begin
        due_results.push_back(mk_result(ST_NOT_FOUND, r.key_value, set_count, 1'b1));
      end else begin
        for (int i = pos; i + 1 < set_count; i++) set_vals[i] = set_vals[i+1];
        set_count--;
        due_results.push_back(mk_result(ST_REMOVED, r.key_value, set_count, 1'b1));
      end
    end else begin
      n = set_count;
      for (int i = 0; i < n; i++) begin
        if (r.req_type == REQ_CLEAR) begin
          due_results.push_back(mk_result(ST_REMOVED, set_vals[i], n - 1 - i, i + 1 == n));
        end else begin
          due_results.push_back(mk_result(ST_LISTED, set_vals[i], n, i + 1 == n));
        end
      end
      if (r.req_type == REQ_CLEAR) set_count = 0;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_idle = 0;
    end else begin
      if (req_valid && !req_stall) begin
        predict_set_op(req);
        n_sent++;
      end
      if (!(req_valid && req_stall)) begin
        if (send_idle > 0) begin
          send_idle--;
          req_valid <= 1'b0;
        end else if (req_backlog.size() > 0 &&
                     !(req_backlog[0].drain && due_results.size() > 0)) begin
          req <= req_backlog[0].r;
          req_valid <= 1'b1;
          void'(req_backlog.pop_front());
          send_idle = pick_gap(n_sent);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
      recv_idle = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (due_results.size() == 0) begin
          $error("unexpected result item: status %0d value %0d", rsp.status, rsp.out_value);
          n_err++;
        end else begin
          want = due_results.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, rsp.status);
            n_err++;
          end
          if (rsp.out_value !== want.out_value) begin
            $error("out_value: expected %0d actual %0d", want.out_value, rsp.out_value);
            n_err++;
          end
          if (rsp.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d actual %0d", want.entry_count,
                   rsp.entry_count);
            n_err++;
          end
          if (rsp.last_result !== want.last_result) begin
            $error("last_result: expected %0d actual %0d", want.last_result,
                   rsp.last_result);
            n_err++;
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (recv_idle > 0) begin
        recv_idle--;
        rsp_stall <= 1'b1;
      end else if (!long_hold_done && n_sent >= 60) begin
        long_hold_done = 1;
        recv_idle = LONG_HOLD - 1;
        rsp_stall <= 1'b1;
      end else begin
        recv_idle = pick_gap(n_sent);
        if (recv_idle > 0) begin
          recv_idle--;
          rsp_stall <= 1'b1;
        end else begin
          rsp_stall <= 1'b0;
        end
      end
    end
  end

  // watchdog: cycles with no item moving on either side
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_req(req_type_t t, logic signed [31:0] k, bit drain = 0);
    backlog_t b;
    b.drain = drain;
    b.r.req_type = t;
    b.r.key_value = k;
    req_backlog.push_back(b);
  endtask

  // mostly keys from a small pool so that hits are common
  function automatic logic signed [31:0] pick_key();
    if ($urandom_range(0, 99) < 65) return key_pool[$urandom_range(0, 23)];
    return $urandom;
  endfunction

  function automatic req_type_t pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return REQ_INSERT;
    if (r < 80) return REQ_DELETE;
    if (r < 92) return REQ_DUMP;
    return REQ_CLEAR;
  endfunction

  // stimulus and end of run
  initial begin
    int n_gen;
    int kind;
    int len;
    bit drain;
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = 0;
    key_pool[3] = -1;
    key_pool[4] = 1;
    for (int i = 5; i < 24; i++) key_pool[i] = $urandom;

    // directed: empty set cases, extremes, duplicate, absent delete
    add_req(REQ_DUMP, 0);
    add_req(REQ_CLEAR, 32'sh7fff_ffff);
    add_req(REQ_DELETE, 5);
    add_req(REQ_INSERT, 32'sh7fff_ffff);
    add_req(REQ_INSERT, 32'sh8000_0000);
    add_req(REQ_INSERT, 0);
    add_req(REQ_INSERT, -1);
    add_req(REQ_INSERT, 1);
    add_req(REQ_INSERT, 32'sh7fff_ffff);
    add_req(REQ_DELETE, 5);
    add_req(REQ_DUMP, 32'sh5555_aaaa);
    add_req(REQ_DELETE, 32'sh8000_0000);
    add_req(REQ_DELETE, 32'sh7fff_ffff);
    add_req(REQ_DUMP, -1);
    add_req(REQ_CLEAR, 0);
    add_req(REQ_DUMP, 0, 1);
    n_gen = 16;

    // random sequences
    while (n_gen < NUM_ITEMS) begin
      kind = $urandom_range(0, 9);
      drain = ($urandom_range(0, 7) == 0);
      if (kind < 2) begin
        // fill past capacity, then list
        len = $urandom_range(17, 20);
        for (int i = 0; i < len; i++) add_req(REQ_INSERT, $urandom, drain && i == 0);
        add_req(REQ_INSERT, pick_key());
        add_req(REQ_DUMP, $urandom);
        n_gen += len + 2;
      end else if (kind < 6) begin
        for (int i = 0; i < 8; i++) add_req(pick_op(), pick_key(), drain && i == 0);
        n_gen += 8;
      end else if (kind < 8) begin
        for (int i = 0; i < 8; i++) add_req(REQ_DELETE, pick_key(), drain && i == 0);
        n_gen += 8;
      end else if (kind == 8) begin
        add_req(REQ_CLEAR, $urandom, drain);
        add_req(REQ_DELETE, pick_key());
        add_req(REQ_DUMP, $urandom);
        add_req(REQ_CLEAR, $urandom);
        n_gen += 4;
      end else begin
        for (int i = 0; i < 4; i++) begin
          add_req(req_type_t'($urandom_range(0, 3)), $urandom, drain && i == 0);
        end
        n_gen += 4;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (req_backlog.size() > 0 || req_valid || due_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
